[rtl/hpe_pkg.sv]
// Shared constants, item type and codes for the Hermite polynomial evaluator.
`timescale 1ns / 1ps
`default_nettype none
package hpe_pkg;

	localparam int MAX_ORDER = 15;
	localparam int KW        = $clog2(MAX_ORDER + 1);
	localparam int XW        = 16;
	localparam int NW        = 4;
	localparam int VW        = 64;
	localparam int PW        = XW + VW;
	localparam int DW        = PW + 2;
	localparam int FW        = VW + KW + 2;
	localparam int SHIFT     = 11;

	localparam logic [PW-1:0] RND_HALF = PW'(1) << (SHIFT - 1);
	localparam logic [VW-1:0] SAT_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [VW-1:0] SAT_MIN  = 64'h8000_0000_0000_0000;
	localparam logic [VW-1:0] ONE_Q16  = 64'h0000_0000_0001_0000;

	localparam logic [1:0] DERIV_VALUE = 2'd0;
	localparam logic [1:0] DERIV_FIRST = 2'd1;

	typedef struct packed {
		logic [XW-1:0] x;
		logic [VW-1:0] prev;
		logic [VW-1:0] cur;
		logic [KW-1:0] steps;
		logic [KW-1:0] nc;
		logic [1:0]    d;
		logic          ovf;
	} hpe_item_t;

endpackage
`default_nettype wire

[rtl/hpe_cell.sv]
// One recurrence step cell of the Hermite chain.
`timescale 1ns / 1ps
`default_nettype none
module hpe_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic [hpe_pkg::KW-1:0] step_k,
	input  wire logic              in_valid,
	input  wire hpe_pkg::hpe_item_t in_item,
	output logic                   out_valid,
	output hpe_pkg::hpe_item_t     out_item
);
	import hpe_pkg::*;

	logic signed [XW-1:0] xs;
	logic signed [VW-1:0] cur_s;
	logic signed [VW-1:0] prev_s;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] rnd;
	logic [KW:0]          fac;
	logic signed [FW-1:0] t2p;
	logic signed [DW-1:0] t1;
	logic signed [DW-1:0] t2;
	logic signed [DW-1:0] diff;
	logic                 fits;
	logic                 active;
	hpe_item_t            nxt;
	logic                 valid_q;
	hpe_item_t            item_q;

	assign xs     = $signed(in_item.x);
	assign cur_s  = $signed(in_item.cur);
	assign prev_s = $signed(in_item.prev);
	assign fac    = {step_k - KW'(1), 1'b0};

	assign prod = PW'(xs) * PW'(cur_s);
	assign rnd  = prod + $signed(RND_HALF);
	assign t1   = DW'(rnd >>> SHIFT);
	assign t2p  = FW'(prev_s) * FW'($signed({1'b0, fac}));
	assign t2   = DW'(t2p);
	assign diff = t1 - t2;
	assign fits = (diff[DW-1:VW-1] == '0) || (diff[DW-1:VW-1] == '1);

	assign active = !in_item.ovf && (step_k <= in_item.steps);

	always_comb begin
		nxt = in_item;
		if (active) begin
			if (fits) begin
				nxt.prev = in_item.cur;
				nxt.cur  = diff[VW-1:0];
			end else begin
				nxt.cur = diff[DW-1] ? SAT_MIN : SAT_MAX;
				nxt.ovf = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule
`default_nettype wire

[rtl/hpe_final.sv]
// Final cell: derivative scaling, flag selection and output register.
`timescale 1ns / 1ps
`default_nettype none
module hpe_final (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire logic               in_valid,
	input  wire hpe_pkg::hpe_item_t in_item,
	output logic                    m_tvalid,
	output logic [hpe_pkg::VW-1:0]  m_tdata,
	output logic [1:0]              m_tuser
);
	import hpe_pkg::*;

	logic signed [VW-1:0] cur_s;
	logic [KW:0]          fac2;
	logic signed [FW-1:0] dp;
	logic                 dfits;
	logic [VW-1:0]        val;
	logic                 ovf;
	logic                 uns;
	logic                 valid_q;
	logic [VW-1:0]        val_q;
	logic                 ovf_q;
	logic                 uns_q;

	assign cur_s = $signed(in_item.cur);
	assign fac2  = {in_item.nc, 1'b0};
	assign dp    = FW'(cur_s) * FW'($signed({1'b0, fac2}));
	assign dfits = (dp[FW-1:VW-1] == '0) || (dp[FW-1:VW-1] == '1);

	always_comb begin
		val = '0;
		ovf = 1'b0;
		uns = 1'b0;
		unique case (in_item.d)
			DERIV_VALUE: begin
				val = in_item.cur;
				ovf = in_item.ovf;
			end
			DERIV_FIRST: begin
				if (in_item.nc == '0) begin
					val = '0;
				end else if (in_item.ovf) begin
					val = in_item.cur;
					ovf = 1'b1;
				end else if (dfits) begin
					val = dp[VW-1:0];
				end else begin
					val = dp[FW-1] ? SAT_MIN : SAT_MAX;
					ovf = 1'b1;
				end
			end
			default: begin
				uns = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			val_q <= val;
			ovf_q <= ovf;
			uns_q <= uns;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = val_q;
	assign m_tuser  = {uns_q, ovf_q};

endmodule
`default_nettype wire

[rtl/hermite_polynomial_eval.sv]
// Top level of the Hermite polynomial evaluator: input setup and cell chain.
// An item passes through every recurrence cell register and then the final output register before m_tvalid.
// Throughput: one item per cycle while the output is not stalled; the chain holds one item per recurrence cell.
// Each cell runs one recurrence step; the last cell applies the 2n derivative scale.
// Backpressure stalls the whole chain while the output result waits.
// Reset clears all valid bits asynchronously; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module hermite_polynomial_eval (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // arg_x [15:0], poly_order [19:16], zero [23:20]
	input  wire logic [1:0]  s_tuser,  // deriv_order [1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,  // poly_value [63:0]
	output logic [1:0]       m_tuser   // overflow_flag [0], unsupported_flag [1]
);
	import hpe_pkg::*;

	logic            adv;
	logic [NW-1:0]   n_in;
	logic [KW-1:0]   nc;
	logic [KW-1:0]   steps;
	hpe_item_t       head;
	logic            v     [MAX_ORDER+1];
	hpe_item_t       it    [MAX_ORDER+1];

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign n_in     = s_tdata[19:16];

	always_comb begin
		if ({KW'(0), n_in} > (KW + NW)'(MAX_ORDER)) begin
			nc = KW'(MAX_ORDER);
		end else begin
			nc = KW'(n_in);
		end
		if ((s_tuser == DERIV_FIRST) && (nc != '0)) begin
			steps = nc - KW'(1);
		end else begin
			steps = nc;
		end
		head.x     = s_tdata[15:0];
		head.prev  = '0;
		head.cur   = ONE_Q16;
		head.steps = steps;
		head.nc    = nc;
		head.d     = s_tuser;
		head.ovf   = 1'b0;
	end

	assign v[0]  = s_tvalid;
	assign it[0] = head;

	for (genvar g = 0; g < MAX_ORDER; g++) begin : g_cell
		hpe_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.step_k   (KW'(g + 1)),
			.in_valid (v[g]),
			.in_item  (it[g]),
			.out_valid(v[g+1]),
			.out_item (it[g+1])
		);
	end

	hpe_final u_final (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_valid(v[MAX_ORDER]),
		.in_item (it[MAX_ORDER]),
		.m_tvalid(m_tvalid),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule
`default_nettype wire

[rtl/hpe_checker.sv]
// Port-level checker for the Hermite polynomial evaluator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module hpe_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	a_unsup: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> (m_tdata == 64'd0) && !m_tuser[0])
		else $error("unsupported result not zero");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			(m_tdata == 64'h7FFF_FFFF_FFFF_FFFF) || (m_tdata == 64'h8000_0000_0000_0000))
		else $error("overflow result not saturated");

endmodule

bind hermite_polynomial_eval hpe_checker u_hpe_checker (.*);
`default_nettype wire

[dv/tb_hermite_polynomial_eval.sv]
// Testbench for hermite_polynomial_eval: directed and random stream traffic against a scoreboard.
`timescale 1ns / 1ps
module tb_hermite_polynomial_eval;
	import hpe_pkg::*;

	localparam int DIRECTED_COUNT = 25;
	localparam int RANDOM_ITEMS   = 1300;
	localparam int DRAIN_CYCLES   = 4 * (MAX_ORDER + 1);
	localparam int CYCLE_LIMIT    = 400000;

	localparam logic [1:0] DERIV_SECOND = 2'd2;
	localparam logic [1:0] DERIV_THIRD  = 2'd3;

	typedef enum int {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_PERIODIC} ready_mode_t;

	typedef struct packed {
		logic [63:0] value;
		logic        ovf;
		logic        unsup;
	} hermite_result_t;

	class hermite_scoreboard;
		hermite_result_t pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function hermite_result_t eval_poly(logic signed [15:0] x, int n);
			logic signed [127:0] wx, cur, prev, t1, t2, diff;
			hermite_result_t r;
			int k;
			wx = x;
			cur = 128'sd65536;
			prev = '0;
			r = '0;
			for (k = 1; k <= n; k++) begin
				t1 = (wx * cur + 128'sd1024) >>> SHIFT;
				t2 = prev * (2 * (k - 1));
				diff = t1 - t2;
				if (diff[127:63] != {65{diff[127]}}) begin
					r.ovf = 1'b1;
					r.value = diff[127] ? SAT_MIN : SAT_MAX;
					return r;
				end
				prev = cur;
				cur = diff;
			end
			r.value = cur[63:0];
			return r;
		endfunction

		function hermite_result_t predict(logic [15:0] x, logic [3:0] order, logic [1:0] deriv);
			hermite_result_t r;
			logic signed [127:0] h, scaled;
			int n;
			n = (int'(order) > MAX_ORDER) ? MAX_ORDER : int'(order);
			r = '0;
			if (deriv == DERIV_VALUE) begin
				r = eval_poly(x, n);
			end else if (deriv == DERIV_FIRST) begin
				if (n > 0) begin
					r = eval_poly(x, n - 1);
					if (!r.ovf) begin
						h = $signed(r.value);
						scaled = h * (2 * n);
						if (scaled[127:63] != {65{scaled[127]}}) begin
							r.ovf = 1'b1;
							r.value = scaled[127] ? SAT_MIN : SAT_MAX;
						end else begin
							r.value = scaled[63:0];
						end
					end
				end
			end else begin
				r.unsup = 1'b1;
			end
			return r;
		endfunction

		function void note_input(logic [15:0] x, logic [3:0] order, logic [1:0] deriv);
			pending.push_back(predict(x, order, deriv));
		endfunction

		function void check_result(logic [63:0] value, logic [1:0] flags);
			hermite_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: result with no transfer pending, actual value %h flags %b",
					$time, value, flags);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (value !== e.value) begin
				$display("%0t: poly_value expected %h actual %h", $time, e.value, value);
				errors++;
			end
			if (flags[0] !== e.ovf) begin
				$display("%0t: overflow_flag expected %b actual %b", $time, e.ovf, flags[0]);
				errors++;
			end
			if (flags[1] !== e.unsup) begin
				$display("%0t: unsupported_flag expected %b actual %b", $time, e.unsup, flags[1]);
				errors++;
			end
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;

	logic        s_acc = 1'b0;
	int          cycle_count = 0;
	ready_mode_t ready_mode = RDY_ALWAYS;
	hermite_scoreboard sb;

	logic [21:0] directed_items [0:DIRECTED_COUNT-1] = '{
		{DERIV_VALUE,  4'd0,  16'h0000},
		{DERIV_VALUE,  4'd15, 16'h7FFF},
		{DERIV_VALUE,  4'd15, 16'h8000},
		{DERIV_FIRST,  4'd15, 16'h7FFF},
		{DERIV_FIRST,  4'd15, 16'h8000},
		{DERIV_VALUE,  4'd1,  16'h1000},
		{DERIV_VALUE,  4'd2,  16'hF000},
		{DERIV_VALUE,  4'd15, 16'h0000},
		{DERIV_FIRST,  4'd15, 16'h0000},
		{DERIV_FIRST,  4'd0,  16'h0000},
		{DERIV_FIRST,  4'd0,  16'h1000},
		{DERIV_FIRST,  4'd1,  16'h1000},
		{DERIV_SECOND, 4'd0,  16'h7FFF},
		{DERIV_THIRD,  4'd15, 16'h8000},
		{DERIV_THIRD,  4'd0,  16'h0000},
		{DERIV_VALUE,  4'd15, 16'h0001},
		{DERIV_VALUE,  4'd15, 16'hFFFF},
		{DERIV_VALUE,  4'd5,  16'h2000},
		{DERIV_FIRST,  4'd6,  16'hE000},
		{DERIV_VALUE,  4'd7,  16'h7FFF},
		{DERIV_VALUE,  4'd15, 16'h1000},
		{DERIV_FIRST,  4'd15, 16'hF000},
		{DERIV_VALUE,  4'd10, 16'h0800},
		{DERIV_SECOND, 4'd3,  16'h5555},
		{DERIV_FIRST,  4'd9,  16'hAAAA}
	};

	hermite_polynomial_eval dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),  // arg_x [15:0], poly_order [19:16], zero [23:20]
		.s_tuser  (s_tuser),  // deriv_order [1:0]
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),  // poly_value [63:0]
		.m_tuser  (m_tuser)   // overflow_flag [0], unsupported_flag [1]
	);

	always #4 clk = ~clk;

	always @(negedge clk) begin
		s_acc = s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count % 256 == 0)
			ready_mode <= ready_mode_t'($urandom_range(0, 3));
		case (ready_mode)
			RDY_ALWAYS: m_tready <= 1'b1;
			RDY_HALF:   m_tready <= 1'($urandom_range(0, 1));
			RDY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
			default:    m_tready <= cycle_count[3];
		endcase
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[hermite_polynomial_eval] ERROR");
			$finish;
		end
	end

	function automatic logic [21:0] random_item();
		logic [15:0] x;
		logic [3:0]  n;
		logic [1:0]  d;
		int          pick;
		case ($urandom_range(0, 4))
			0, 1: x = 16'($urandom_range(0, 16'hFFFF));
			2, 3: x = 16'($urandom_range(0, 20480) - 10240);
			default: begin
				case ($urandom_range(0, 5))
					0: x = 16'h7FFF;
					1: x = 16'h8000;
					2: x = 16'h0000;
					3: x = 16'h1000;
					4: x = 16'hF000;
					default: x = 16'h8001;
				endcase
			end
		endcase
		n = 4'($urandom_range(0, 15));
		pick = $urandom_range(0, 9);
		if (pick < 4)
			d = DERIV_VALUE;
		else if (pick < 8)
			d = DERIV_FIRST;
		else
			d = $urandom_range(0, 1) ? DERIV_SECOND : DERIV_THIRD;
		return {d, n, x};
	endfunction

	task automatic send_item(input logic [15:0] x, input logic [3:0] n, input logic [1:0] d);
		s_tdata  <= {4'b0000, n, x};
		s_tuser  <= d;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_acc);
		sb.note_input(x, n, d);
	endtask

	task automatic idle_sender(input int cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	initial begin
		logic [21:0] item;
		int idx, burst, gap, total;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		total = DIRECTED_COUNT + RANDOM_ITEMS;
		idx = 0;
		while (idx < total) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && idx < total) begin
				item = (idx < DIRECTED_COUNT) ? directed_items[idx] : random_item();
				send_item(item[15:0], item[19:16], item[21:20]);
				idx++;
				burst--;
			end
			case ($urandom_range(0, 7))
				0, 1: gap = 0;
				2:    gap = $urandom_range(13, 30);
				default: gap = $urandom_range(1, 12);
			endcase
			if (gap > 0)
				idle_sender(gap);
		end
		idle_sender(1);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("[hermite_polynomial_eval] OK");
		end else begin
			$display("[hermite_polynomial_eval] ERROR");
		end
		$finish;
	end

endmodule
